>>> rtl/hsta_pkg.sv
// ----------------------------------------------------------------------------
// hsta_pkg
// shared widths, register indexes and fixed-point helpers of the
// highlight / shadow tone adjust unit
// ----------------------------------------------------------------------------
package hsta_pkg;

  localparam int CH_W       = 8;            // one color channel
  localparam int PIX_W      = 24;           // pixel word
  localparam int PCT_W      = 7;            // slider percent
  localparam int CFG_W      = 7;            // widest register
  localparam int CFG_IDX_W  = 2;            // register index
  localparam int TONE_DEPTH = 1 << CH_W;    // one entry per channel value

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGHLIGHT = 2'd0,
    CFG_SHADOW    = 2'd1,
    CFG_FORMAT    = 2'd2
  } cfg_idx_t;

  localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
  localparam logic [12:0]      DIV100_RECIP = 13'd5243;   // 2^19 / 100, rounded up
  localparam int               DIV100_SHIFT = 19;
  localparam logic [14:0]      HI_SAT_LIMIT = 15'd25600;  // c*hv/100 >= 256 from here on
  localparam logic [8:0]       SH_BIAS      = 9'd265;

  // floor(x / 100), exact for x below 43699
  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(DIV100_RECIP);
    return p[DIV100_SHIFT +: 9];
  endfunction

  // pct * 255 / 100 with the percent saturated at 100
  function automatic logic [CH_W-1:0] pct_level(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    logic [14:0]      x;
    logic [8:0]       q;
    p = (pct > PCT_FULL) ? PCT_FULL : pct;
    x = {p, 8'b0} - 15'(p);
    q = div100(x);
    return q[CH_W-1:0];
  endfunction

endpackage

>>> rtl/highlight_shadow_tone_adjust_unit.sv
// ----------------------------------------------------------------------------
// highlight_shadow_tone_adjust_unit
// per-channel highlight / shadow tone curve applied through a lookup table
// ----------------------------------------------------------------------------
// usage:
//   config port: cfg_we / cfg_index / cfg_data write highlight_pct, shadow_pct
//   and pixel_format; writes must only be made while no word is in flight
//   (not enforced); pixel channel: pix_valid / pix_stall / pixel_in, one
//   word per pixel, RGB888 or RGB565 in the low 16 bits as selected by
//   pixel_format; result channel: res_valid / res_stall / pixel_out, same
//   format as the input (RGB565 results have bits 23:16 cleared)
// throughput and pipeline:
//   one pixel per cycle while pix_stall is low; the accepting edge reads the
//   three channels from the tone tables into the read stage, which loads
//   the output register pixel_out when res_stall does not hold it
// table rebuild:
//   after reset and after every register write the 256-entry tone table is
//   rebuilt one entry at a time through a shared shift-subtract divider;
//   pix_stall stays high until the last entry is written
// stalls:
//   res_stall holds the output word; the read stage keeps one more word, and
//   pix_stall rises only when both are full or the tables are being rebuilt
// ----------------------------------------------------------------------------
module highlight_shadow_tone_adjust_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hsta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsta_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  logic [hsta_pkg::PIX_W-1:0]    pixel_in,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [hsta_pkg::PIX_W-1:0]    pixel_out
);
  import hsta_pkg::*;

  // table builder states
  typedef enum logic [3:0] {
    ST_LEVEL,
    ST_HV_INIT,
    ST_HV_DIV,
    ST_H_MUL,
    ST_H_SUM,
    ST_S_CHECK,
    ST_S_DIV,
    ST_S_MUL,
    ST_S_SUB,
    ST_READY
  } state_t;

  // configuration registers
  logic [PCT_W-1:0] highlight_pct;
  logic [PCT_W-1:0] shadow_pct;
  logic             pixel_format;

  // table builder
  state_t           state;
  logic [CH_W-1:0]  idx;          // entry being built
  logic [CH_W-1:0]  h_lvl;        // highlight threshold
  logic [CH_W-1:0]  s_lvl;        // shadow threshold
  logic [14:0]      hv;           // highlight gain in percent
  logic [22:0]      prod;         // shared multiplier result
  logic [CH_W-1:0]  c1;           // channel value after highlight
  logic             c1_sat;       // forced to full scale, shadow bypassed

  // shift-subtract divider, one quotient bit per cycle
  logic [14:0]      div_rem;
  logic [22:0]      div_den;
  logic [14:0]      div_q;
  logic [3:0]       div_cnt;
  logic             div_ge;
  logic [14:0]      div_q_next;

  logic [8:0]       q_mul;
  logic [8:0]       h_sum;
  logic             last_entry;
  logic             shadow_skip;

  // table write port
  logic             wr_en;
  logic [CH_W-1:0]  wr_data;

  // tone tables: two copies so three channels are read per cycle
  logic [CH_W-1:0]  tone_a [TONE_DEPTH];
  logic [CH_W-1:0]  tone_b [TONE_DEPTH];

  // pixel pipeline
  logic             pix_accept;
  logic             advance;
  logic             s1_valid;
  logic             s1_format;
  logic [CH_W-1:0]  addr_r;
  logic [CH_W-1:0]  addr_g;
  logic [CH_W-1:0]  addr_b;
  logic [CH_W-1:0]  rd_r;
  logic [CH_W-1:0]  rd_g;
  logic [CH_W-1:0]  rd_b;

  // --------------------------------------------------------------------------
  // configuration registers; an index beyond the list is ignored
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      highlight_pct <= PCT_FULL;
      shadow_pct    <= '0;
      pixel_format  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGHLIGHT: highlight_pct <= cfg_data[PCT_W-1:0];
        CFG_SHADOW:    shadow_pct    <= cfg_data[PCT_W-1:0];
        CFG_FORMAT:    pixel_format  <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // table builder datapath
  // --------------------------------------------------------------------------
  assign div_ge      = {8'b0, div_rem} >= div_den;
  assign div_q_next  = {div_q[13:0], div_ge};
  assign q_mul       = div100(prod[14:0]);       // prod stays below the exact range here
  assign h_sum       = {1'b0, idx} + q_mul;
  assign last_entry  = (idx == {CH_W{1'b1}});
  // full-scale highlight, shadow off, or at/below the shadow level
  assign shadow_skip = c1_sat || (s_lvl == '0) || (c1 <= s_lvl);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = c1;
    case (state)
      ST_S_CHECK: begin
        if (c1_sat || (s_lvl == '0)) begin
          wr_en   = 1'b1;
          wr_data = c1;
        end else if (c1 <= s_lvl) begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
      end
      ST_S_SUB: begin
        wr_en   = 1'b1;
        wr_data = c1 - q_mul[CH_W-1:0];
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // table builder sequencer; any register write restarts it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LEVEL;
      idx   <= '0;
    end else if (cfg_we) begin
      state <= ST_LEVEL;
      idx   <= '0;
    end else begin
      case (state)
        ST_LEVEL: begin
          h_lvl <= pct_level(highlight_pct);
          s_lvl <= pct_level(shadow_pct);
          state <= ST_HV_INIT;
        end
        ST_HV_INIT: begin
          // hv = (255 - H) * 100 / H + 1, fifteen quotient bits
          div_rem <= 15'(16'(8'hFF - h_lvl) * 16'd100);
          div_den <= {1'b0, h_lvl, 14'b0};
          div_q   <= '0;
          div_cnt <= 4'd14;
          state   <= ST_HV_DIV;
        end
        ST_HV_DIV, ST_S_DIV: begin
          if (div_ge) begin
            div_rem <= div_rem - div_den[14:0];
          end
          div_q   <= div_q_next;
          div_den <= div_den >> 1;
          div_cnt <= div_cnt - 4'd1;
          if (div_cnt == '0) begin
            if (state == ST_HV_DIV) begin
              hv    <= div_q_next + 15'd1;
              state <= ST_H_MUL;
            end else begin
              state <= ST_S_MUL;
            end
          end
        end
        ST_H_MUL: begin
          prod  <= 23'(idx) * 23'(hv);
          state <= ST_H_SUM;
        end
        ST_H_SUM: begin
          c1_sat <= 1'b0;
          if (h_lvl == 8'hFF) begin
            c1 <= idx;
          end else if (idx >= h_lvl) begin
            c1     <= 8'hFF;
            c1_sat <= 1'b1;
          end else if (prod >= 23'(HI_SAT_LIMIT) || h_sum[CH_W]) begin
            c1 <= 8'hFF;
          end else begin
            c1 <= h_sum[CH_W-1:0];
          end
          state <= ST_S_CHECK;
        end
        ST_S_CHECK: begin
          if (shadow_skip) begin
            if (last_entry) begin
              state <= ST_READY;
            end else begin
              idx   <= idx + 8'd1;
              state <= ST_H_MUL;
            end
          end else begin
            // sv = (255 - c) * 100 / (265 - S), below 100 so seven bits
            div_rem <= 15'(16'(8'hFF - c1) * 16'd100);
            div_den <= 23'({SH_BIAS - 9'(s_lvl), 6'b0});
            div_q   <= '0;
            div_cnt <= 4'd6;
            state   <= ST_S_DIV;
          end
        end
        ST_S_MUL: begin
          prod  <= 23'(c1) * 23'(div_q[6:0]);
          state <= ST_S_SUB;
        end
        ST_S_SUB: begin
          if (last_entry) begin
            state <= ST_READY;
          end else begin
            idx   <= idx + 8'd1;
            state <= ST_H_MUL;
          end
        end
        ST_READY: ;
        default: state <= ST_LEVEL;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pixel side handshake
  // --------------------------------------------------------------------------
  assign advance    = !res_valid || !res_stall;
  assign pix_stall  = (state != ST_READY) || (s1_valid && !advance);
  assign pix_accept = pix_valid && !pix_stall;

  // table addresses: RGB565 channels widened by shifting into the top bits
  always_comb begin
    if (pixel_format) begin
      addr_r = {pixel_in[15:11], 3'b0};
      addr_g = {pixel_in[10:5], 2'b0};
      addr_b = {pixel_in[4:0], 3'b0};
    end else begin
      addr_r = pixel_in[23:16];
      addr_g = pixel_in[15:8];
      addr_b = pixel_in[7:0];
    end
  end

  // tone tables: written by the builder, read by accepted words
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tone_a[idx] <= wr_data;
      tone_b[idx] <= wr_data;
    end
    if (pix_accept) begin
      rd_r      <= tone_a[addr_r];
      rd_g      <= tone_a[addr_g];
      rd_b      <= tone_b[addr_b];
      s1_format <= pixel_format;
    end
  end

  // read stage and output register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pix_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
    end
  end

  // output word: RGB565 repacked by dropping the low channel bits
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (s1_format) begin
        pixel_out <= {8'b0, rd_r[7:3], rd_g[7:2], rd_b[7:3]};
      end else begin
        pixel_out <= {rd_r, rd_g, rd_b};
      end
    end
  end

`ifndef SYNTHESIS
  // a register write always restarts the table rebuild
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> state == ST_LEVEL)
    else $error("table rebuild not restarted after register write");

  // a word parked in the read stage keeps its table data
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(rd_r) && $stable(rd_g) && $stable(rd_b))
    else $error("read stage lost its data while stalled");

  // the shadow quotient stays below one hundred
  a_shadow_q: assert property (@(posedge clk) disable iff (rst)
    state == ST_S_MUL |-> div_q < 15'd100)
    else $error("shadow quotient out of range");
`endif

endmodule
